>>> rtl/core/sorted_process_priority_queue_top_assert.svh
// Assertion macros shared by the queue RTL.
`ifndef SORTED_PROCESS_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PROCESS_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SPPQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SPPQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/sppq_pkg.sv
`default_nettype none

package sppq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int KEY_W = 16;

	// command codes
	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_DEQ  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	// result codes
	localparam logic [1:0] RES_OK    = 2'd0;
	localparam logic [1:0] RES_EMPTY = 2'd1;
	localparam logic [1:0] RES_FULL  = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT_UP
	} cell_op_t;

	typedef struct packed {
		logic [15:0] pid;
		logic [7:0]  prio;
		logic [15:0] remaining;
		logic [15:0] waiting;
		logic [2:0]  status;
		logic [15:0] handle;
	} entry_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		cell_op_t         op;
		logic             key_sel;
		logic [KEY_W-1:0] key;
		entry_t           entry;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/sppq_req_if.sv
`default_nettype none

interface sppq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] pid;
	logic [7:0]  priority_req;
	logic [15:0] remaining_time;
	logic [15:0] waiting_time;
	logic [2:0]  run_status;
	logic [15:0] process_handle;

	modport source (
		output valid, command, pid, priority_req, remaining_time, waiting_time,
			run_status, process_handle,
		input  ready
	);
	modport sink (
		input  valid, command, pid, priority_req, remaining_time, waiting_time,
			run_status, process_handle,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/core/sppq_rsp_if.sv
`default_nettype none

interface sppq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_code;
	logic [15:0] head_pid;
	logic [7:0]  head_priority;
	logic [15:0] head_remaining;
	logic [15:0] head_waiting;
	logic [2:0]  head_status;
	logic [15:0] head_handle;
	logic        now_empty;

	modport source (
		output valid, result_code, head_pid, head_priority, head_remaining,
			head_waiting, head_status, head_handle, now_empty,
		input  ready
	);
	modport sink (
		input  valid, result_code, head_pid, head_priority, head_remaining,
			head_waiting, head_status, head_handle, now_empty,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/core/sppq_cfg_if.sv
`default_nettype none

interface sppq_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sppq_cell.sv
`default_nettype none

module sppq_cell #(
	parameter bit HEAD = 1'b0
) (
	input  wire                  clk,
	input  sppq_pkg::cell_ctrl_t ctrl,
	input  wire                  occupied,
	input  wire                  found_in,
	input  sppq_pkg::entry_t     left_entry,
	input  sppq_pkg::entry_t     right_entry,
	output logic                 found_out,
	output sppq_pkg::entry_t     entry
);
	import sppq_pkg::*;

	entry_t           entry_q;
	logic [KEY_W-1:0] my_key;
	logic             flag;

	assign my_key = ctrl.key_sel ? entry_q.remaining : {8'b0, entry_q.prio};

	// head slot: new entry goes first only when the head's key is strictly greater than the new key
	always_comb begin
		if (!occupied)
			flag = 1'b1;
		else if (HEAD)
			flag = my_key > ctrl.key;
		else
			flag = my_key >= ctrl.key;
	end

	assign found_out = found_in | flag;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (found_in)
					entry_q <= left_entry;
				else if (flag)
					entry_q <= ctrl.entry;
			end
			CELL_SHIFT_UP: entry_q <= right_entry;
			default: ;
		endcase
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

>>> rtl/core/sorted_process_priority_queue_top.sv
// Channel | Modport | Word
// --------+---------+----------------------------------------------------
// req     | sink    | command, pid, priority_req, remaining_time,
//         |         | waiting_time, run_status, process_handle
// rsp     | source  | result_code, head_* fields, now_empty
// cfg     | sink    | data = sort_key (0 priority, 1 remaining time)
//
// Each word is latched first; then the whole cell row compares against the
// new key and shifts (insert) or pulls toward the head (dequeue) in parallel.
// The next word is taken the cycle after.
// The result sits in an output register; a new word is accepted while it waits,
// but its execute cycle holds until that register frees up.
// arst_n clears the entry count, the FSM, rsp.valid and sort_key; cell
// contents have no reset. cfg.ready is always high.
`default_nettype none

module sorted_process_priority_queue_top #(
	parameter int QUEUE_DEPTH = sppq_pkg::QUEUE_DEPTH_DEF
) (
	input wire         clk,
	input wire         arst_n,
	sppq_req_if.sink   req,
	sppq_rsp_if.source rsp,
	sppq_cfg_if.sink   cfg
);
	import sppq_pkg::*;

	`include "sorted_process_priority_queue_top_assert.svh"

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	state_t           state_q, state_d;
	logic [1:0]       cmd_q;
	entry_t           new_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic             sort_key_q;

	logic             out_valid_q;
	logic [1:0]       out_code_q;
	entry_t           out_head_q;
	logic             out_empty_q;

	logic             out_free;
	logic             exec_fire;
	logic             is_full;
	logic             is_empty;
	logic [1:0]       res_code;
	entry_t           res_head;
	cell_ctrl_t       ctrl;

	entry_t           cell_entry [QUEUE_DEPTH];
	logic             found      [QUEUE_DEPTH];

	// config register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sort_key_q <= 1'b0;
		else if (cfg.valid)
			sort_key_q <= cfg.data;
	end

	assign is_full   = count_q == CNT_W'(QUEUE_DEPTH);
	assign is_empty  = count_q == '0;
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = state_q == ST_IDLE;

	// FSM state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state, cell op and result
	always_comb begin
		state_d      = state_q;
		exec_fire    = 1'b0;
		ctrl.op      = CELL_HOLD;
		ctrl.key_sel = sort_key_q;
		ctrl.key     = sort_key_q ? new_q.remaining : {8'b0, new_q.prio};
		ctrl.entry   = new_q;
		count_d      = count_q;
		res_code     = RES_OK;
		res_head     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					exec_fire = 1'b1;
					state_d   = ST_IDLE;
					unique case (cmd_q) inside
						CMD_ENQ: begin
							if (is_full) begin
								res_code = RES_FULL;
							end else begin
								ctrl.op = CELL_INSERT;
								count_d = count_q + 1'b1;
							end
						end
						CMD_DEQ, CMD_PEEK: begin
							if (is_empty) begin
								res_code = RES_EMPTY;
							end else begin
								res_head = cell_entry[0];
								if (cmd_q == CMD_DEQ) begin
									ctrl.op = CELL_SHIFT_UP;
									count_d = count_q - 1'b1;
								end
							end
						end
						default: ;  // command three: no operation
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// latched request word
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q           <= req.command;
			new_q.pid       <= req.pid;
			new_q.prio      <= req.priority_req;
			new_q.remaining <= req.remaining_time;
			new_q.waiting   <= req.waiting_time;
			new_q.status    <= req.run_status;
			new_q.handle    <= req.process_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_d;
	end

	// cell row: slot 0 is the head
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   fin;

		if (i == 0) begin : g_first
			assign left_e = new_q;
			assign fin    = 1'b0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign fin    = found[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_e = cell_entry[i];
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		sppq_cell #(
			.HEAD (i == 0)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (count_q > CNT_W'(i)),
			.found_in    (fin),
			.left_entry  (left_e),
			.right_entry (right_e),
			.found_out   (found[i]),
			.entry       (cell_entry[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (exec_fire)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			out_code_q  <= res_code;
			out_head_q  <= res_head;
			out_empty_q <= count_d == '0;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.result_code    = out_code_q;
	assign rsp.head_pid       = out_head_q.pid;
	assign rsp.head_priority  = out_head_q.prio;
	assign rsp.head_remaining = out_head_q.remaining;
	assign rsp.head_waiting   = out_head_q.waiting;
	assign rsp.head_status    = out_head_q.status;
	assign rsp.head_handle    = out_head_q.handle;
	assign rsp.now_empty      = out_empty_q;

	`SPPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH),
		"entry count above depth")
	`SPPQ_ASSERT_NXT(a_accept_exec, req.valid && req.ready, state_q == ST_EXEC,
		"accepted word not executed next")
	`SPPQ_ASSERT_IMP(a_insert_slot, ctrl.op == CELL_INSERT, found[QUEUE_DEPTH-1],
		"insert found no slot in the row")
	`SPPQ_ASSERT_NXT(a_deq_count, ctrl.op == CELL_SHIFT_UP,
		count_q == $past(count_q) - 1'b1, "dequeue did not drop the count")

endmodule

`default_nettype wire
